@@ rtl/core/random_spanning_tree_maze_step_core_assert.svh @@
// Assertion macros shared by the maze step core modules.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef RANDOM_SPANNING_TREE_MAZE_STEP_CORE_ASSERT_SVH
`define RANDOM_SPANNING_TREE_MAZE_STEP_CORE_ASSERT_SVH

// Same-cycle implication
`define RSTM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rstm_pkg.sv @@
package rstm_pkg;

  // Grid size limits
  localparam int MAX_COLS   = 16;
  localparam int MAX_ROWS   = 16;
  localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;

  // Derived widths
  localparam int CELL_W = $clog2(CELL_TOTAL);
  localparam int GRP_W  = $clog2(CELL_TOTAL + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int CNT_W  = $clog2(2 * CELL_TOTAL);

  // Fixed field widths
  localparam int RND_W     = 31;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int XY_W      = 4;
  localparam int DIV_CNT_W = $clog2(RND_W);

  // Register reset value and the grid size it gives
  localparam int CFG_DIM_RESET = 16;
  localparam int RST_COLS = (CFG_DIM_RESET > MAX_COLS) ? MAX_COLS : CFG_DIM_RESET;
  localparam int RST_ROWS = (CFG_DIM_RESET > MAX_ROWS) ? MAX_ROWS : CFG_DIM_RESET;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic restart;
    logic scan_start;
    logic scan_pick;
    logic force_one;
    logic div_start;
    logic relabel_start;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic groups_le1;
    logic count_zero;
    logic scan_done;
    logic div_done;
    logic relabel_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/rstm_ctrl.sv @@
`include "random_spanning_tree_maze_step_core_assert.svh"

module rstm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           func_i,
  output logic           in_stall_o,
  output rstm_pkg::cmd_t cmd_o,
  input  rstm_pkg::sts_t sts_i
);

  localparam logic FUNC_RESTART = 1'b0;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RESTART = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SCAN1   = 4'd3;
  localparam logic [3:0] S_COUNT   = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_SCAN2   = 4'd6;
  localparam logic [3:0] S_RELABEL = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state_q;
  logic [3:0] state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (func_i == FUNC_RESTART) ? S_RESTART : S_CHECK;
        end
      end
      S_RESTART: begin
        cmd_o.restart = 1'b1;
        state_d       = S_FINISH;
      end
      S_CHECK: begin
        if (sts_i.groups_le1) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (sts_i.scan_done) state_d = S_COUNT;
      end
      S_COUNT: begin
        if (sts_i.count_zero) begin
          cmd_o.force_one = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_pick  = 1'b1;
          state_d          = S_SCAN2;
        end
      end
      S_SCAN2: begin
        if (sts_i.scan_done) begin
          cmd_o.relabel_start = 1'b1;
          state_d             = S_RELABEL;
        end
      end
      S_RELABEL: begin
        if (sts_i.relabel_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `RSTM_ASSERT_SAME(a_scan_done_in_scan, sts_i.scan_done,
                    state_q == S_SCAN1 || state_q == S_SCAN2,
                    "scan finished outside a scan pass")
  `RSTM_ASSERT_SAME(a_div_done_in_div, sts_i.div_done, state_q == S_DIV,
                    "divider finished outside the divide state")

endmodule

@@ rtl/core/rstm_datapath.sv @@
`include "random_spanning_tree_maze_step_core_assert.svh"

module rstm_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rstm_pkg::cmd_t                       cmd_i,
  output rstm_pkg::sts_t                       sts_o,
  input  logic [rstm_pkg::RND_W-1:0]           random_value_i,
  input  logic                                 cfg_we_i,
  input  logic [rstm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rstm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [rstm_pkg::XY_W-1:0]            wall_x_o,
  output logic [rstm_pkg::XY_W-1:0]            wall_y_o,
  output logic                                 wall_dir_o,
  output logic                                 removed_o,
  output logic                                 done_res_o
);

  localparam int CELL_W = rstm_pkg::CELL_W;
  localparam int GRP_W  = rstm_pkg::GRP_W;
  localparam int COL_W  = rstm_pkg::COL_W;
  localparam int ROW_W  = rstm_pkg::ROW_W;
  localparam int CNT_W  = rstm_pkg::CNT_W;
  localparam int RND_W  = rstm_pkg::RND_W;
  localparam int CFG_W  = rstm_pkg::CFG_W;
  localparam int XY_W   = rstm_pkg::XY_W;
  localparam int DCW    = rstm_pkg::DIV_CNT_W;
  localparam int XEXT_W = COL_W + XY_W;
  localparam int YEXT_W = ROW_W + XY_W;

  // Configuration and latched grid
  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [COL_W-1:0] dim_w;
  logic [ROW_W-1:0] dim_h;
  logic [COL_W-1:0] act_w_q;
  logic [ROW_W-1:0] act_h_q;
  logic [GRP_W-1:0] ncell_q, groups_q;

  // Label store
  logic [CELL_W-1:0]                   lab_mem [rstm_pkg::CELL_TOTAL];
  logic [rstm_pkg::CELL_TOTAL-1:0]     vld_q;
  logic [CELL_W-1:0]                   addr_a, addr_b;
  logic [CELL_W-1:0]                   rd_a_q, rd_b_q, addr_a1_q, addr_b1_q;
  logic                                va_q, vb_q;
  logic [CELL_W-1:0]                   lab_a1, lab_b1;
  logic                                wr_en;

  // Scan pipeline
  logic              sc_issue_q, sc_mode_q, sc_last;
  logic [CELL_W-1:0] sc_q;
  logic [COL_W-1:0]  sx_q, p1_x_q, p2_x_q;
  logic [ROW_W-1:0]  sy_q, p1_y_q, p2_y_q;
  logic              row_end;
  logic              p1_v_q, p2_v_q;
  logic [CELL_W-1:0] lab_a2_q, lab_b2_q;
  logic              right_ok, down_ok, hit_r, hit_d, scan_done;
  logic [CNT_W-1:0]  n_q;

  // Selection
  logic              found_q;
  logic [COL_W-1:0]  sel_x_q;
  logic [ROW_W-1:0]  sel_y_q;
  logic              sel_dir_q;
  logic [CELL_W-1:0] target_q, merged_q;

  // Divider
  logic              div_busy_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [RND_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;

  // Relabel pass
  logic              rl_issue_q, rl_last, r1_v_q, r1_last_q, relabel_done;
  logic [CELL_W-1:0] rl_i_q;

  // Result
  logic              res_removed_q, out_valid_q, out_free;
  logic [XEXT_W-1:0] sel_x_ext;
  logic [YEXT_W-1:0] sel_y_ext;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(rstm_pkg::CFG_DIM_RESET);
      cfg_h_q <= CFG_W'(rstm_pkg::CFG_DIM_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rstm_pkg::REG_CELL_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end else if (cfg_idx_i == rstm_pkg::REG_CELL_HEIGHT) begin
        cfg_h_q <= cfg_data_i;
      end
    end
  end

  // Clamp the requested size into 1..max
  always_comb begin
    priority if (cfg_w_q == '0) begin
      dim_w = COL_W'(1);
    end else if (32'(cfg_w_q) > rstm_pkg::MAX_COLS) begin
      dim_w = COL_W'(rstm_pkg::MAX_COLS);
    end else begin
      dim_w = COL_W'(cfg_w_q);
    end
    priority if (cfg_h_q == '0) begin
      dim_h = ROW_W'(1);
    end else if (32'(cfg_h_q) > rstm_pkg::MAX_ROWS) begin
      dim_h = ROW_W'(rstm_pkg::MAX_ROWS);
    end else begin
      dim_h = ROW_W'(cfg_h_q);
    end
  end

  // Active grid and group count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q  <= COL_W'(rstm_pkg::RST_COLS);
      act_h_q  <= ROW_W'(rstm_pkg::RST_ROWS);
      ncell_q  <= GRP_W'(rstm_pkg::RST_COLS * rstm_pkg::RST_ROWS);
      groups_q <= GRP_W'(rstm_pkg::RST_COLS * rstm_pkg::RST_ROWS);
    end else begin
      if (cmd_i.restart) begin
        act_w_q  <= dim_w;
        act_h_q  <= dim_h;
        ncell_q  <= GRP_W'(dim_w) * GRP_W'(dim_h);
        groups_q <= GRP_W'(dim_w) * GRP_W'(dim_h);
      end else if (cmd_i.force_one) begin
        groups_q <= GRP_W'(1);
      end else if (relabel_done) begin
        groups_q <= groups_q - GRP_W'(1);
      end
    end
  end

  // Port addresses: port A walks cells, port B looks one row down
  assign addr_a = rl_issue_q ? rl_i_q : sc_q;
  assign addr_b = sc_q + CELL_W'(act_w_q);

  // Entry valid bits; an unwritten cell carries its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.restart) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr_a1_q] <= 1'b1;
    end
  end

  // Label memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) lab_mem[addr_a1_q] <= target_q;
    rd_a_q    <= lab_mem[addr_a];
    rd_b_q    <= lab_mem[addr_b];
    va_q      <= vld_q[addr_a];
    vb_q      <= vld_q[addr_b];
    addr_a1_q <= addr_a;
    addr_b1_q <= addr_b;
  end

  assign lab_a1 = va_q ? rd_a_q : addr_a1_q;
  assign lab_b1 = vb_q ? rd_b_q : addr_b1_q;

  // Scan address walk, row-major over the active grid
  assign row_end = (sx_q + COL_W'(1)) == act_w_q;
  assign sc_last = row_end && ((sy_q + ROW_W'(1)) == act_h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_issue_q <= 1'b0;
      sc_mode_q  <= 1'b0;
      sc_q       <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      p1_v_q     <= 1'b0;
      p2_v_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        sc_issue_q <= 1'b1;
        sc_mode_q  <= cmd_i.scan_pick;
        sc_q       <= '0;
        sx_q       <= '0;
        sy_q       <= '0;
      end else if (sc_issue_q) begin
        sc_q <= sc_q + CELL_W'(1);
        if (row_end) begin
          sx_q <= '0;
          sy_q <= sy_q + ROW_W'(1);
        end else begin
          sx_q <= sx_q + COL_W'(1);
        end
        if (sc_last) sc_issue_q <= 1'b0;
      end
      p1_v_q <= sc_issue_q;
      p2_v_q <= p1_v_q;
    end
  end

  // Scan stage payload
  always_ff @(posedge clk_i) begin
    p1_x_q   <= sx_q;
    p1_y_q   <= sy_q;
    p2_x_q   <= p1_x_q;
    p2_y_q   <= p1_y_q;
    lab_a2_q <= lab_a1;
    lab_b2_q <= lab_b1;
  end

  // Candidate test for the cell in stage 2; stage 1 holds its right neighbor
  assign right_ok  = p2_v_q && ((p2_x_q + COL_W'(1)) != act_w_q) && (lab_a2_q != lab_a1);
  assign down_ok   = p2_v_q && ((p2_y_q + ROW_W'(1)) != act_h_q) && (lab_a2_q != lab_b2_q);
  assign scan_done = p2_v_q && ((p2_x_q + COL_W'(1)) == act_w_q)
                            && ((p2_y_q + ROW_W'(1)) == act_h_q);
  assign hit_r     = sc_mode_q && right_ok && (n_q == rem_q);
  assign hit_d     = sc_mode_q && down_ok && ((n_q + CNT_W'(right_ok)) == rem_q);

  // Candidate count and selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      n_q     <= '0;
      found_q <= 1'b0;
    end else if (p2_v_q) begin
      n_q <= n_q + CNT_W'(right_ok) + CNT_W'(down_ok);
      if (hit_r || hit_d) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_r) begin
      sel_x_q   <= p2_x_q;
      sel_y_q   <= p2_y_q;
      sel_dir_q <= 1'b0;
      target_q  <= lab_a2_q;
      merged_q  <= lab_a1;
    end else if (hit_d) begin
      sel_x_q   <= p2_x_q;
      sel_y_q   <= p2_y_q;
      sel_dir_q <= 1'b1;
      target_q  <= lab_a2_q;
      merged_q  <= lab_b2_q;
    end
  end

  // Restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem_q, dvd_q[RND_W-1]};
  assign rem_ge = rem_sh >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DCW'(RND_W - 1);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - DCW'(1);
      if (div_cnt_q == '0) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dvd_q <= random_value_i;
    end else if (div_busy_q) begin
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
    end else if (div_busy_q) begin
      rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[CNT_W-1:0];
    end
  end

  // Relabel pass: read a cell, rewrite it next cycle if it is in the merged group
  assign rl_last      = (GRP_W'(rl_i_q) + GRP_W'(1)) == ncell_q;
  assign wr_en        = r1_v_q && (lab_a1 == merged_q);
  assign relabel_done = r1_v_q && r1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_issue_q <= 1'b0;
      rl_i_q     <= '0;
      r1_v_q     <= 1'b0;
      r1_last_q  <= 1'b0;
    end else begin
      if (cmd_i.relabel_start) begin
        rl_issue_q <= 1'b1;
        rl_i_q     <= '0;
      end else if (rl_issue_q) begin
        rl_i_q <= rl_i_q + CELL_W'(1);
        if (rl_last) rl_issue_q <= 1'b0;
      end
      r1_v_q    <= rl_issue_q;
      r1_last_q <= rl_issue_q && rl_last;
    end
  end

  // Result flag and output register
  assign out_free  = !out_valid_q || !out_stall_i;
  assign sel_x_ext = XEXT_W'(sel_x_q);
  assign sel_y_ext = YEXT_W'(sel_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_removed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        res_removed_q <= 1'b0;
      end else if (relabel_done) begin
        res_removed_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      wall_x_o   <= res_removed_q ? sel_x_ext[XY_W-1:0] : '0;
      wall_y_o   <= res_removed_q ? sel_y_ext[XY_W-1:0] : '0;
      wall_dir_o <= res_removed_q && sel_dir_q;
      removed_o  <= res_removed_q;
      done_res_o <= groups_q <= GRP_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;

  // Status
  assign sts_o.groups_le1   = groups_q <= GRP_W'(1);
  assign sts_o.count_zero   = n_q == '0;
  assign sts_o.scan_done    = scan_done;
  assign sts_o.div_done     = div_busy_q && (div_cnt_q == '0);
  assign sts_o.relabel_done = relabel_done;
  assign sts_o.out_free     = out_free;

  `RSTM_ASSERT_SAME(a_groups_bounded, 1'b1, groups_q <= ncell_q,
                    "group count above cell count")
  `RSTM_ASSERT_SAME(a_relabel_has_pick, cmd_i.relabel_start, found_q,
                    "relabel started without a selected wall")
  `RSTM_ASSERT_NEXT(a_restart_clean, cmd_i.restart,
                    vld_q == '0 && groups_q == ncell_q,
                    "restart left merged state behind")

endmodule

@@ rtl/core/random_spanning_tree_maze_step_core.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------------
// in       | in        | in_valid_i / in_stall_o  | func_i, random_value_i
// out      | out       | out_valid_o / out_stall_i | wall_x_o, wall_y_o, wall_dir_o, removed_o,
//          |           |                        | done_res_o
// cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A merge step runs two scans over the label memory, a remainder unit over the
// 31-bit random word and a relabel pass through the memory's single write port.
// A restart or a step on a finished maze skips the scans and the remainder unit.
// Reset brings the grid up at once; per-cell valid bits stand in for the labels.
// One item is in work at a time; the next is taken while a result waits in the
// output register, and a stalled result holds the following one in its last state.

module random_spanning_tree_maze_step_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [rstm_pkg::RND_W-1:0]       random_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rstm_pkg::XY_W-1:0]        wall_x_o,
  output logic [rstm_pkg::XY_W-1:0]        wall_y_o,
  output logic                             wall_dir_o,
  output logic                             removed_o,
  output logic                             done_res_o,
  input  logic                             cfg_we_i,
  input  logic [rstm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rstm_pkg::CFG_W-1:0]       cfg_data_i
);

  rstm_pkg::cmd_t cmd;
  rstm_pkg::sts_t sts;

  // Sequencer
  rstm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Label store, scanner, divider and result register
  rstm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .random_value_i (random_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .wall_x_o       (wall_x_o),
    .wall_y_o       (wall_y_o),
    .wall_dir_o     (wall_dir_o),
    .removed_o      (removed_o),
    .done_res_o     (done_res_o)
  );

endmodule

@@ dv/maze_tb_pkg.sv @@
`timescale 1ns / 100ps

package maze_tb_pkg;

  // Operation carried by an input transfer
  typedef enum logic {
    FUNC_RESTART = 1'b0,
    FUNC_MERGE   = 1'b1
  } maze_func_e;

  // Which wall of a cell a merge opens
  typedef enum logic {
    WALL_RIGHT = 1'b0,
    WALL_DOWN  = 1'b1
  } wall_dir_e;

  // One result transfer
  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    wall_dir_e  dir;
    logic       removed;
    logic       done;
  } wall_report_t;

endpackage

@@ dv/maze_step_checker.sv @@
`timescale 1ns / 100ps

module maze_step_checker
  import rstm_pkg::*;
  import maze_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 func_i,
  input  logic [RND_W-1:0]     random_value_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [XY_W-1:0]      wall_x_i,
  input  logic [XY_W-1:0]      wall_y_i,
  input  logic                 wall_dir_i,
  input  logic                 removed_i,
  input  logic                 done_res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [1:0] WALLS_CLOSED = 2'b11;

  // Shadow of the maze: labels, walls, live group count, latched size
  logic [7:0]       label_q [CELL_TOTAL];
  logic [1:0]       walls_q [CELL_TOTAL];
  logic [8:0]       groups_left_q;
  int               cols_q;
  int               rows_q;
  logic [CFG_W-1:0] width_reg_q;
  logic [CFG_W-1:0] height_reg_q;

  wall_report_t     report_q [$];

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // Every cell in its own group, all walls up, size taken from the registers
  function automatic void restart_grid();
    int i;
    cols_q = clamp_size(width_reg_q, MAX_COLS);
    rows_q = clamp_size(height_reg_q, MAX_ROWS);
    for (i = 0; i < CELL_TOTAL; i++) begin
      label_q[i] = i[7:0];
      walls_q[i] = WALLS_CLOSED;
    end
    groups_left_q = 9'(cols_q * rows_q);
  endfunction

  // Row-major walk over walls between different groups, right before down.
  // Returns the number of such walls; the one numbered pick lands in cx/cy/dir.
  function automatic int scan_walls(input int pick, output int cx, output int cy,
                                    output wall_dir_e dir);
    int n, c, x, y;
    n   = 0;
    cx  = 0;
    cy  = 0;
    dir = WALL_RIGHT;
    for (y = 0; y < rows_q; y++) begin
      for (x = 0; x < cols_q; x++) begin
        c = y * cols_q + x;
        if (x + 1 < cols_q && label_q[c] != label_q[c + 1]) begin
          if (n == pick) begin
            cx = x; cy = y; dir = WALL_RIGHT;
          end
          n++;
        end
        if (y + 1 < rows_q && label_q[c] != label_q[c + cols_q]) begin
          if (n == pick) begin
            cx = x; cy = y; dir = WALL_DOWN;
          end
          n++;
        end
      end
    end
    return n;
  endfunction

  // Applies one input item to the shadow and returns the result it should give
  function automatic wall_report_t predict_step(input maze_func_e f,
                                                input logic [RND_W-1:0] rnd);
    wall_report_t r;
    wall_dir_e    dir;
    int           count, pick, cx, cy, c, i;
    logic [7:0]   keep, absorbed;
    r = '0;
    if (f == FUNC_RESTART) begin
      restart_grid();
      r.done = (groups_left_q <= 1);
      return r;
    end
    // finished maze: nothing moves
    if (groups_left_q <= 1) begin
      r.done = 1'b1;
      return r;
    end
    count = scan_walls(-1, cx, cy, dir);
    // no wall left to open although groups remain
    if (count == 0) begin
      groups_left_q = 9'd1;
      r.done = 1'b1;
      return r;
    end
    pick = int'(32'(rnd) % 32'(count));
    void'(scan_walls(pick, cx, cy, dir));
    c    = cy * cols_q + cx;
    keep = label_q[c];
    if (dir == WALL_RIGHT) begin
      walls_q[c][0] = 1'b0;
      absorbed = label_q[c + 1];
    end else begin
      walls_q[c][1] = 1'b0;
      absorbed = label_q[c + cols_q];
    end
    for (i = 0; i < cols_q * rows_q; i++) begin
      if (label_q[i] == absorbed) label_q[i] = keep;
    end
    groups_left_q = groups_left_q - 9'd1;
    r.x       = cx[3:0];
    r.y       = cy[3:0];
    r.dir     = dir;
    r.removed = 1'b1;
    r.done    = (groups_left_q <= 1);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // Results are checked before the input of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    wall_report_t want;
    if (!rst_ni) begin
      width_reg_q  = CFG_DIM_RESET;
      height_reg_q = CFG_DIM_RESET;
      restart_grid();
      report_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $display("%0t: result with none expected, actual x=%0d y=%0d dir=%0d rm=%0d done=%0d",
                   $time, wall_x_i, wall_y_i, wall_dir_i, removed_i, done_res_i);
          fail_count_o++;
        end else begin
          want = report_q.pop_front();
          check_field("wall_x", want.x, wall_x_i);
          check_field("wall_y", want.y, wall_y_i);
          check_field("wall_dir", want.dir, wall_dir_i);
          check_field("removed", want.removed, removed_i);
          check_field("done_res", want.done, done_res_i);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CELL_WIDTH) width_reg_q = cfg_data_i;
        else if (cfg_idx_i == REG_CELL_HEIGHT) height_reg_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_step(maze_func_e'(func_i), random_value_i);
        report_q.insert(report_q.size(), want);
      end
    end
    pending_o = report_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import rstm_pkg::*;
  import maze_tb_pkg::*;

  localparam int ITEM_GOAL     = 1000;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 8;
  // sink holds off once this many results are in, long enough to back up the input
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  logic [RND_W-1:0]     random_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [XY_W-1:0]      wall_x_o;
  logic [XY_W-1:0]      wall_y_o;
  logic                 wall_dir_o;
  logic                 removed_o;
  logic                 done_res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int fail_count;
  int pending;
  int sent;

  random_spanning_tree_maze_step_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wall_x_o       (wall_x_o),
    .wall_y_o       (wall_y_o),
    .wall_dir_o     (wall_dir_o),
    .removed_o      (removed_o),
    .done_res_o     (done_res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  maze_step_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .random_value_i (random_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wall_x_i       (wall_x_o),
    .wall_y_i       (wall_y_o),
    .wall_dir_i     (wall_dir_o),
    .removed_i      (removed_o),
    .done_res_i     (done_res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = ~clk_i;
  end

  // One input transfer; valid stays up afterwards unless the next call idles
  task automatic send_item(input maze_func_e f, input logic [RND_W-1:0] rnd);
    int pct;
    pct = (sent >= 400 && sent < 550) ? 0 : IDLE_PCT;
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // Drop valid and wait until every result has come back; the checker's count
  // is read at the falling edge so the last accepted transfer is in it
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle
  task automatic set_size(input int w, input int h);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CELL_WIDTH;
    cfg_data_i <= w[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= REG_CELL_HEIGHT;
    cfg_data_i <= h[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [RND_W-1:0] any_word();
    return RND_W'($urandom());
  endfunction

  // Result sink: random stalls, one long hold-off, one stretch with none
  initial begin
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) taken++;
      if (taken == HOLD_AT && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (taken >= 600 && taken < 800) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Stimulus
  initial begin
    int w, h, cells, steps;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_RESTART;
    random_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_CELL_WIDTH;
    cfg_data_i     = '0;
    sent           = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // merges on the grid that reset brings up, extreme random words
    send_item(FUNC_MERGE, '0);
    send_item(FUNC_MERGE, '1);
    send_item(FUNC_MERGE, 31'h2AAA_AAAA);
    // zero size acts as a single cell: done at once, then a step after completion
    set_size(0, 0);
    send_item(FUNC_RESTART, '1);
    send_item(FUNC_MERGE, 31'h5555_5555);
    // oversized width clamps, single row
    set_size(31, 1);
    send_item(FUNC_RESTART, '0);
    send_item(FUNC_MERGE, '1);
    send_item(FUNC_MERGE, '0);
    // single column, height just past the max
    set_size(1, 17);
    send_item(FUNC_RESTART, any_word());
    send_item(FUNC_MERGE, any_word());
    // 2x2 maze; size write mid-maze only counts at the next restart
    set_size(2, 2);
    send_item(FUNC_RESTART, '0);
    send_item(FUNC_MERGE, any_word());
    set_size(5, 5);
    send_item(FUNC_MERGE, '1);
    send_item(FUNC_MERGE, any_word());
    send_item(FUNC_MERGE, any_word());
    send_item(FUNC_RESTART, '1);
    send_item(FUNC_MERGE, '0);

    // random mazes, mostly small and run to completion, a few on the full grid
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(15) == 0) begin
        w     = $urandom_range(16, 31);
        h     = $urandom_range(16, 31);
        steps = $urandom_range(8, 24);
      end else begin
        w     = $urandom_range(0, 6);
        h     = $urandom_range(0, 6);
        cells = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
        steps = cells - 1 + $urandom_range(0, 2);
      end
      set_size(w, h);
      if ($urandom_range(7) != 0) send_item(FUNC_RESTART, any_word());
      repeat (steps) begin
        if ($urandom_range(19) == 0) send_item(FUNC_RESTART, any_word());
        else send_item(FUNC_MERGE, any_word());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rstm_pkg.sv
rtl/core/rstm_ctrl.sv
rtl/core/rstm_datapath.sv
rtl/core/random_spanning_tree_maze_step_core.sv
dv/maze_tb_pkg.sv
dv/maze_step_checker.sv
dv/tb_top.sv
